// ===== sv/gha_pkg.sv =====
// Shared types and constants of the generational handle allocator.
`timescale 1ns / 1ps
package gha_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = IDX_W + 1;
	localparam int GEN_W      = 16;
	localparam int OWNER_W    = 16;
	localparam int OP_W       = 2;
	localparam int STAT_W     = 2;
	localparam int ENTRY_W    = GEN_W + 1;

	localparam logic [GEN_W-1:0]   GEN_MAX    = {GEN_W{1'b1}};
	localparam logic [CNT_W-1:0]   SLOTS_FULL = CNT_W'(SLOT_COUNT);
	localparam logic [OWNER_W-1:0] OWNER_RST  = OWNER_W'(1);

	localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_STALE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_LOOK = 3'b100
	} state_t;

	// One slot table word.
	typedef struct packed {
		logic             live;
		logic [GEN_W-1:0] gen;
	} entry_t;

	// Requests from the control to the free stack.
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [IDX_W-1:0] push_slot;
	} stk_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] depth;
		logic             empty;
		logic             full;
	} stk_stat_t;

	typedef struct packed {
		logic [5:0]         pad;
		logic [GEN_W-1:0]   handle_generation;
		logic [IDX_W-1:0]   handle_index;
		logic [OWNER_W-1:0] handle_owner;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]         pad;
		logic [CNT_W-1:0]   live_count;
		logic [GEN_W-1:0]   new_generation;
		logic [IDX_W-1:0]   new_index;
		logic [OWNER_W-1:0] new_owner;
		logic               is_alive;
		logic [STAT_W-1:0]  status;
	} out_beat_t;

endpackage

// ===== sv/generational_handle_allocator_core.sv =====
// Top level of the generational handle allocator: control, slot table and free stack.
`timescale 1ns / 1ps
// Issues, retires and checks handles (owner, index, generation) for 1024 slots. The operation
// code travels in s_tuser (0 create, 1 destroy, 2 or 3 check) and each input beat gives exactly
// one result beat. A create reuses the most recently freed slot, or else the next never-used
// one; a destroy of a current handle frees its slot and bumps the generation, and a slot at the
// largest generation is retired for good. Each operation reads and writes the slot table RAM at
// most once. An item goes from S_IDLE to S_LOOK, or through S_POP first for a create that pops
// the free stack, whose RAM read comes first; the result beat is registered as it leaves S_LOOK
// and the next item is accepted back in S_IDLE, so the block takes no new item while one is in
// flight. A result that the sink has not taken yet holds the following item in its write-back
// step, so a stalled sink blocks the input after one more item.
// Table words at or above the high-water mark are never used, so no clearing is needed after reset.
// Write owner_id only while the block is idle; doing so makes every earlier handle foreign.
module generational_handle_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gha_pkg::OWNER_W-1:0]  cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [15:0] handle_owner, [25:16] handle_index, [41:26] handle_generation
	input  logic [47:0]                  s_tdata,
	// [1:0] op
	input  logic [gha_pkg::OP_W-1:0]     s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [1:0] status, [2] is_alive, [18:3] new_owner, [28:19] new_index,
	// [44:29] new_generation, [55:45] live_count
	output logic [55:0]                  m_tdata
);
	import gha_pkg::*;

	state_t            state_q;
	logic [OWNER_W-1:0] owner_id_q;
	logic [CNT_W-1:0]  high_water_q;
	logic [CNT_W-1:0]  live_total_q;

	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  slot_q;
	logic [GEN_W-1:0]  hgen_q;
	logic              fresh_q;
	logic              cap_q;
	logic              hok_q;

	logic              m_tvalid_q;
	out_beat_t         out_q;

	in_beat_t          in_beat;
	logic              accept;
	logic              finish;

	stk_req_t          stk_req;
	stk_stat_t         stk_stat;
	logic [IDX_W-1:0]  pop_slot;

	logic              tbl_re;
	logic [IDX_W-1:0]  tbl_raddr;
	logic              tbl_we;
	entry_t            tbl_wdata;
	logic [ENTRY_W-1:0] tbl_rword;
	entry_t            tbl_rd;

	logic              current;
	logic [GEN_W-1:0]  cur_gen;
	logic [CNT_W-1:0]  live_next;
	out_beat_t         out_next;

	assign in_beat  = in_beat_t'(s_tdata);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign finish   = (state_q == S_LOOK) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q[55:0];
	assign tbl_rd   = entry_t'(tbl_rword);

	gha_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (stk_req),
		.stat    (stk_stat),
		.pop_slot(pop_slot)
	);

	gha_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(slot_q),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rword)
	);

	// Table reads: the handle's slot at acceptance, or the popped slot in S_POP, the cycle after acceptance.
	always_comb begin
		tbl_re    = 1'b0;
		tbl_raddr = in_beat.handle_index;
		if (accept && s_tuser != OP_CREATE) begin
			tbl_re = 1'b1;
		end else if (state_q == S_POP) begin
			tbl_re    = 1'b1;
			tbl_raddr = pop_slot;
		end
	end

	// Finishing step: update the slot, the stack and the live count, and form the result.
	always_comb begin
		cur_gen   = fresh_q ? '0 : tbl_rd.gen;
		current   = hok_q && tbl_rd.live && (tbl_rd.gen == hgen_q);
		tbl_we    = 1'b0;
		tbl_wdata = tbl_rd;
		live_next = live_total_q;
		stk_req.push      = 1'b0;
		stk_req.pop       = accept && (s_tuser == OP_CREATE) && !stk_stat.empty;
		stk_req.push_slot = slot_q;
		out_next  = '0;
		case (op_q)
			OP_CREATE: begin
				if (cap_q) begin
					out_next.status = STAT_FULL;
				end else begin
					tbl_we             = finish;
					tbl_wdata.live     = 1'b1;
					tbl_wdata.gen      = cur_gen;
					live_next          = live_total_q + CNT_W'(1);
					out_next.new_owner = owner_id_q;
					out_next.new_index = slot_q;
					out_next.new_generation = cur_gen;
				end
			end
			OP_DESTROY: begin
				if (current) begin
					tbl_we         = finish;
					tbl_wdata.live = 1'b0;
					if (tbl_rd.gen != GEN_MAX) begin
						tbl_wdata.gen = tbl_rd.gen + GEN_W'(1);
						stk_req.push  = finish;
					end
					if (live_total_q != '0) begin
						live_next = live_total_q - CNT_W'(1);
					end
					out_next.is_alive = 1'b1;
				end else begin
					out_next.status = STAT_STALE;
				end
			end
			default: begin
				if (current) begin
					out_next.is_alive = 1'b1;
				end else begin
					out_next.status = STAT_STALE;
				end
			end
		endcase
		out_next.live_count = live_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			owner_id_q   <= OWNER_RST;
			high_water_q <= '0;
			live_total_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				owner_id_q <= cfg_wdata;
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == OP_CREATE && !stk_stat.empty) begin
							state_q <= S_POP;
						end else begin
							state_q <= S_LOOK;
						end
						if (s_tuser == OP_CREATE && stk_stat.empty &&
							high_water_q != SLOTS_FULL) begin
							high_water_q <= high_water_q + CNT_W'(1);
						end
					end
				end
				S_POP: begin
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					if (finish) begin
						state_q      <= S_IDLE;
						live_total_q <= live_next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			hgen_q  <= in_beat.handle_generation;
			hok_q   <= (in_beat.handle_owner == owner_id_q) &&
				({1'b0, in_beat.handle_index} < high_water_q);
			fresh_q <= stk_stat.empty;
			cap_q   <= stk_stat.empty && (high_water_q == SLOTS_FULL);
			if (s_tuser == OP_CREATE) begin
				slot_q <= high_water_q[IDX_W-1:0];
			end else begin
				slot_q <= in_beat.handle_index;
			end
		end else if (state_q == S_POP) begin
			slot_q <= pop_slot;
		end
		if (finish) begin
			out_q <= out_next;
		end
	end

	// Every live slot lies below the high-water mark.
	a_live_below_hw: assert property (@(posedge clk) disable iff (!arst_n)
		live_total_q <= high_water_q)
		else $error("live count exceeds high-water mark");

	// Free and live slots are disjoint sets of used slots.
	a_free_plus_live: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, stk_stat.depth} + {1'b0, live_total_q}) <= {1'b0, high_water_q})
		else $error("free stack and live slots overlap");

	// A capacity error is reported only when no slot can be found.
	a_full_only_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q.status == STAT_FULL) |->
		(high_water_q == SLOTS_FULL && stk_stat.empty))
		else $error("capacity error with slots available");

	// A result beat held back by the sink keeps the block from finishing another item.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK && m_tvalid_q && !m_tready) |=> (state_q == S_LOOK))
		else $error("item finished over a pending result");

endmodule

// ===== sv/gha_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/gha_stack.sv =====
// LIFO stack of free slot indices, kept in a RAM with a depth counter.
`timescale 1ns / 1ps
module gha_stack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gha_pkg::stk_req_t      req,
	output gha_pkg::stk_stat_t     stat,
	output logic [gha_pkg::IDX_W-1:0] pop_slot
);
	import gha_pkg::*;

	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] depth_dec;
	logic             do_push;
	logic             do_pop;

	assign stat.depth = depth_q;
	assign stat.empty = (depth_q == '0);
	assign stat.full  = (depth_q == SLOTS_FULL);
	assign do_push    = req.push && !stat.full;
	assign do_pop     = req.pop && !stat.empty;
	assign depth_dec  = depth_q - CNT_W'(1);

	// The popped index is registered in the RAM read port and shows on pop_slot in the cycle after the pop.
	gha_ram #(
		.WIDTH(IDX_W),
		.DEPTH(SLOT_COUNT)
	) u_mem (
		.clk  (clk),
		.we   (do_push),
		.waddr(depth_q[IDX_W-1:0]),
		.wdata(req.push_slot),
		.re   (do_pop),
		.raddr(depth_dec[IDX_W-1:0]),
		.rdata(pop_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (do_push) begin
			depth_q <= depth_q + CNT_W'(1);
		end else if (do_pop) begin
			depth_q <= depth_dec;
		end
	end

endmodule
